### hw/rtl/isc_pkg.sv
// Shared types and constants for the idle sleep controller.
`default_nettype none
package isc_pkg;

	localparam int NOW_W    = 32;
	localparam int ACT_W    = 2;
	localparam int CNT_W    = 32;
	localparam int PCT_W    = 7;
	localparam int THR_W    = 31;
	localparam int MODE_W   = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int STEP_W   = 3;

	localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CMD  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WAKE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_DTR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RX  = 2'd2;

	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_MODE      = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	localparam logic [THR_W-1:0]  THR_RESET  = 31'd5000;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_DTR;
	localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;

	// 100 = 2^6 + 2^5 + 2^2
	localparam int MUL_SH_INIT = 6;
	localparam int MUL_SH_MID  = 5;
	localparam int MUL_SH_LAST = 2;
	localparam logic [STEP_W-1:0] MUL_STEPS = 3'd2;
	localparam logic [STEP_W-1:0] DIV_STEPS = 3'd7;

	typedef struct packed {
		logic              enable;
		logic [MODE_W-1:0] mode;
		logic [THR_W-1:0]  threshold;
		logic              begin_pending;
	} isc_cfg_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic update;
		logic clamp;
		logic mul;
		logic mul_last;
		logic div;
		logic out_load;
	} isc_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/isc_req_if.sv
// Event request channel: action and timestamp.
`default_nettype none
interface isc_req_if;
	import isc_pkg::*;

	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, output action, output now_ms, input ready);
	modport sink (input valid, input action, input now_ms, output ready);
	modport monitor (input valid, input action, input now_ms, input ready);
endinterface
`default_nettype wire

### hw/rtl/isc_rsp_if.sv
// Result channel: sleep status and statistics.
`default_nettype none
interface isc_rsp_if;
	import isc_pkg::*;

	logic             valid;
	logic             ready;
	logic             asleep;
	logic             dtr_high;
	logic             rx_wake_request;
	logic             woke_now;
	logic [CNT_W-1:0] wake_total;
	logic [NOW_W-1:0] slept_total_ms;
	logic [PCT_W-1:0] sleep_ratio_pct;

	modport source (output valid, output asleep, output dtr_high, output rx_wake_request,
		output woke_now, output wake_total, output slept_total_ms,
		output sleep_ratio_pct, input ready);
	modport sink (input valid, input asleep, input dtr_high, input rx_wake_request,
		input woke_now, input wake_total, input slept_total_ms,
		input sleep_ratio_pct, output ready);
	modport monitor (input valid, input asleep, input dtr_high, input rx_wake_request,
		input woke_now, input wake_total, input slept_total_ms,
		input sleep_ratio_pct, input ready);
endinterface
`default_nettype wire

### hw/rtl/isc_regs.sv
// APB configuration registers and pending start flag.
`default_nettype none
module isc_regs (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [isc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [isc_pkg::DATA_W-1:0] pwdata,
	output logic      [isc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  wire logic                  clr_pending,
	output isc_pkg::isc_cfg_t          cfg
);
	import isc_pkg::*;

	logic              enable_q;
	logic [MODE_W-1:0] mode_q;
	logic [THR_W-1:0]  thr_q;
	logic              pending_q;
	logic [1:0]        idx;
	logic              wr;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			mode_q    <= MODE_RESET;
			thr_q     <= THR_RESET;
			pending_q <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_ENABLE: begin
					enable_q  <= pwdata[0];
					pending_q <= pwdata[0];
				end
				REG_MODE:      mode_q <= pwdata[MODE_W-1:0];
				REG_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end else if (clr_pending) begin
			pending_q <= 1'b0;
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE:    prdata = DATA_W'(enable_q);
			REG_MODE:      prdata = DATA_W'(mode_q);
			REG_THRESHOLD: prdata = DATA_W'(thr_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg = '{enable: enable_q, mode: mode_q, threshold: thr_q,
		begin_pending: pending_q};
endmodule
`default_nettype wire

### hw/rtl/isc_ctrl.sv
// Controller state machine sequencing update, multiply and divide steps.
`default_nettype none
module isc_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output isc_pkg::isc_cmd_t cmd
);
	import isc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_CLAMP = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_valid && in_ready;
		cmd.load     = (state_q == ST_LOAD);
		cmd.update   = (state_q == ST_UPD);
		cmd.clamp    = (state_q == ST_CLAMP);
		cmd.mul      = (state_q == ST_MUL);
		cmd.mul_last = (step_q == MUL_STEPS - 3'd1);
		cmd.div      = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_LOAD;
				end
				ST_LOAD:  state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_CLAMP;
				ST_CLAMP: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cmd.mul_last) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DIV: begin
					if (step_q == DIV_STEPS - 3'd1) begin
						step_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/isc_dpath.sv
// Datapath: sleep state, time accumulation and percentage divider.
`default_nettype none
module isc_dpath #(
	parameter int TW = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire isc_pkg::isc_cfg_t         cfg,
	input  wire isc_pkg::isc_cmd_t         cmd,
	input  wire logic [isc_pkg::ACT_W-1:0] action,
	input  wire logic [isc_pkg::NOW_W-1:0] now_ms,
	output logic                           asleep,
	output logic                           dtr_high,
	output logic                           rx_wake_request,
	output logic                           woke_now,
	output logic      [isc_pkg::CNT_W-1:0] wake_total,
	output logic      [isc_pkg::NOW_W-1:0] slept_total_ms,
	output logic      [isc_pkg::PCT_W-1:0] sleep_ratio_pct
);
	import isc_pkg::*;

	localparam int W  = TW + PCT_W;
	localparam int CW = (TW > THR_W) ? TW : THR_W;

	logic [ACT_W-1:0] act_q;
	logic [TW-1:0]    now_q;
	logic [TW-1:0]    elapsed_q, idle_q, span_q;

	logic             sleeping_q, dtr_q, started_q;
	logic [TW-1:0]    la_q, ss_q, accum_q, st_q;
	logic [CNT_W-1:0] wake_cnt_q;

	logic             res_asleep_q, res_dtr_q, res_rx_q, res_woke_q, ratio_ok_q;
	logic [TW-1:0]    tot_q, sl_q;
	logic [W-1:0]     rem_q, dvs_q;
	logic [PCT_W-1:0] quo_q;

	logic             begin_w, is_rx, is_dtr, wake_dis, s_mid, thr_ok;
	logic             go_sleep, wake_act, woke, sleeping_new, dtr_new, started_new;
	logic [TW-1:0]    idle_eff, total, span_eff, sl_min;
	logic [W-1:0]     mul_add;

	always_comb begin
		begin_w      = cfg.begin_pending & cfg.enable;
		is_rx        = (cfg.mode == MODE_RX);
		is_dtr       = (cfg.mode == MODE_DTR);
		wake_dis     = !cfg.enable & sleeping_q;
		s_mid        = sleeping_q & cfg.enable & !begin_w;
		idle_eff     = begin_w ? '0 : idle_q;
		thr_ok       = !idle_eff[TW-1] && (CW'(idle_eff) >= CW'(cfg.threshold));
		go_sleep     = (act_q == ACT_TICK) && cfg.enable && !s_mid && thr_ok;
		wake_act     = s_mid && ((act_q == ACT_CMD) || (act_q == ACT_WAKE));
		woke         = (begin_w & sleeping_q) | wake_dis | wake_act;
		sleeping_new = go_sleep | (s_mid & !wake_act);
		dtr_new      = dtr_q;
		if (begin_w || !cfg.enable || (wake_act && !is_rx)) dtr_new = 1'b0;
		if (go_sleep && is_dtr) dtr_new = 1'b1;
		started_new  = started_q | begin_w;
		total        = accum_q + (sleeping_q ? elapsed_q : '0);
		span_eff     = (begin_w && !started_q) ? '0 : span_q;
		sl_min       = (tot_q > span_q) ? span_q : tot_q;
		mul_add      = cmd.mul_last ? (W'(sl_q) << MUL_SH_LAST) : (W'(sl_q) << MUL_SH_MID);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleeping_q <= 1'b0;
			dtr_q      <= 1'b0;
			started_q  <= 1'b0;
			la_q       <= '0;
			ss_q       <= '0;
			accum_q    <= '0;
			st_q       <= '0;
			wake_cnt_q <= '0;
		end else if (cmd.update) begin
			sleeping_q <= sleeping_new;
			dtr_q      <= dtr_new;
			started_q  <= started_new;
			if ((act_q == ACT_CMD) || woke || begin_w) la_q <= now_q;
			if (go_sleep) ss_q <= now_q;
			if (woke) accum_q <= total;
			if (begin_w && !started_q) st_q <= now_q;
			if (wake_dis || wake_act) wake_cnt_q <= wake_cnt_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			now_q <= TW'(now_ms);
		end
		if (cmd.load) begin
			elapsed_q <= now_q - ss_q;
			idle_q    <= now_q - la_q;
			span_q    <= now_q - st_q;
		end
		if (cmd.update) begin
			res_asleep_q <= sleeping_new;
			res_dtr_q    <= dtr_new;
			res_rx_q     <= woke & is_rx;
			res_woke_q   <= woke;
			tot_q        <= total;
			span_q       <= span_eff;
			ratio_ok_q   <= started_new && (span_eff != '0);
		end
		if (cmd.clamp) begin
			sl_q  <= sl_min;
			rem_q <= W'(sl_min) << MUL_SH_INIT;
		end
		if (cmd.mul) begin
			rem_q <= rem_q + mul_add;
			if (cmd.mul_last) dvs_q <= W'(span_q) << (PCT_W - 1);
		end
		if (cmd.div) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[PCT_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[PCT_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.out_load) begin
			asleep          <= res_asleep_q;
			dtr_high        <= res_dtr_q;
			rx_wake_request <= res_rx_q;
			woke_now        <= res_woke_q;
			wake_total      <= wake_cnt_q;
			slept_total_ms  <= NOW_W'(tot_q);
			sleep_ratio_pct <= ratio_ok_q ? quo_q : '0;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/idle_sleep_controller.sv
// Top level of the idle sleep controller.
// Each event request (idle tick, command activity or wake) is taken when the block is idle, and
// its result is formed in these steps in order: form the time differences, update the sleep
// state, clamp the sleep time, two shift-add steps forming 100 times the sleep time, and seven
// restoring-division steps for the percentage. No new request is taken until the finished result
// has gone into the output register; it sits there, so the next request is taken while it waits.
// Timestamps and sleep totals wrap at TIME_WIDTH bits.
`default_nettype none
module idle_sleep_controller #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	isc_req_if.sink                         req,
	isc_rsp_if.source                       rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [isc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [isc_pkg::DATA_W-1:0] pwdata,
	output logic      [isc_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import isc_pkg::*;

	isc_cfg_t cfg;
	isc_cmd_t cmd;
	logic     in_ready;
	logic     out_valid;

	isc_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.clr_pending (cmd.update),
		.cfg         (cfg)
	);

	isc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	isc_dpath #(
		.TW (TIME_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.action          (req.action),
		.now_ms          (req.now_ms),
		.asleep          (rsp.asleep),
		.dtr_high        (rsp.dtr_high),
		.rx_wake_request (rsp.rx_wake_request),
		.woke_now        (rsp.woke_now),
		.wake_total      (rsp.wake_total),
		.slept_total_ms  (rsp.slept_total_ms),
		.sleep_ratio_pct (rsp.sleep_ratio_pct)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
endmodule
`default_nettype wire

### hw/rtl/isc_chk.sv
// Port-level assertions for the idle sleep controller, bound to the top level.
`default_nettype none
module isc_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic                      rsp_rx_wake_request,
	input wire logic                      rsp_woke_now,
	input wire logic [isc_pkg::CNT_W-1:0] rsp_wake_total,
	input wire logic [isc_pkg::NOW_W-1:0] rsp_slept_total_ms,
	input wire logic [isc_pkg::PCT_W-1:0] rsp_sleep_ratio_pct
);
	import isc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_wake_total) && $stable(rsp_slept_total_ms))
		else $error("stalled result changed");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_sleep_ratio_pct <= PCT_FULL)
		else $error("sleep percentage above full scale");

	a_rx_wake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_rx_wake_request |-> rsp_woke_now)
		else $error("rx wake request without a wake");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");
endmodule

bind idle_sleep_controller isc_chk u_isc_chk (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_rx_wake_request (rsp.rx_wake_request),
	.rsp_woke_now        (rsp.woke_now),
	.rsp_wake_total      (rsp.wake_total),
	.rsp_slept_total_ms  (rsp.slept_total_ms),
	.rsp_sleep_ratio_pct (rsp.sleep_ratio_pct)
);
`default_nettype wire
